[design/bcdcc_pkg.sv]
// Shared types and constants for the BCD condition-code unit.
package bcdcc_pkg;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_SUB    = 2'd1,
    OP_WFLAGS = 2'd2,
    OP_TEST   = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    CC_T  = 4'd0,
    CC_F  = 4'd1,
    CC_HI = 4'd2,
    CC_LS = 4'd3,
    CC_CC = 4'd4,
    CC_CS = 4'd5,
    CC_NE = 4'd6,
    CC_EQ = 4'd7,
    CC_VC = 4'd8,
    CC_VS = 4'd9,
    CC_PL = 4'd10,
    CC_MI = 4'd11,
    CC_GE = 4'd12,
    CC_LT = 4'd13,
    CC_GT = 4'd14,
    CC_LE = 4'd15
  } cond_t;

  // Packed so that bit 0 is C and bit 4 is X.
  typedef struct packed {
    logic x;
    logic n;
    logic z;
    logic v;
    logic c;
  } flags_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] source_byte;
    logic [7:0] dest_byte;
    logic [3:0] condition;
    logic [4:0] flags_in;
  } in_t;

  typedef struct packed {
    logic [7:0] result_byte;
    logic [4:0] flags_out;
    logic       condition_true;
  } out_t;

  typedef struct packed {
    logic [7:0] result;
    logic       c;
    logic       v;
    logic       n;
  } arith_res_t;

  localparam logic [9:0] ADD_CARRY_MASK  = 10'h3F0;
  localparam logic [9:0] ADD_CARRY_LIMIT = 10'h090;
  localparam logic [9:0] HI_ADJ_WIDE     = 10'h060;
  localparam logic [7:0] HI_ADJ          = 8'h60;
  localparam logic [3:0] LO_DIGIT_MAX    = 4'd9;
  localparam logic [9:0] LO_ADJ_WIDE     = 10'd6;
  localparam logic [7:0] LO_ADJ          = 8'd6;

endpackage

[design/bcd_alu_condition_codes.sv]
// Top level of the BCD condition-code unit: request register, execute, result register.
// Takes one request per clock while in_stall is low and returns one result per
// request. A request is captured in an input register; once the result register
// can load, the BCD adder, condition check and flag update act on it and load
// the result register, and the C/V/Z/N/X flags are written on that same edge,
// so the next request sees them at once. The condition outcome uses the flags
// as they stood before the request. Add and subtract can only clear Z, never
// set it. in_stall is high only when the input register is full and the result
// register cannot drain.
module bcd_alu_condition_codes import bcdcc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  logic       s1_valid_r, s1_valid_nxt;
  in_t        s1_r, s1_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_t       out_r, out_nxt;
  flags_t     flags_r, flags_nxt;

  logic       out_load;
  logic       s1_fire;
  logic       in_fire;
  op_t        op;
  arith_res_t ar;
  logic       cond_holds;

  assign op       = op_t'(s1_r.opcode);
  assign out_load = ~out_valid_r | ~out_stall;
  assign s1_fire  = s1_valid_r & out_load;
  assign in_stall = s1_valid_r & ~out_load;
  assign in_fire  = in_valid & ~in_stall;

  bcdcc_arith u_arith (
    .subtract (op == OP_SUB),
    .src      (s1_r.source_byte),
    .dst      (s1_r.dest_byte),
    .x_in     (flags_r.x),
    .res      (ar)
  );

  bcdcc_cond u_cond (
    .condition (s1_r.condition),
    .flags     (flags_r),
    .holds     (cond_holds)
  );

  always_comb begin
    flags_nxt = flags_r;
    out_nxt   = out_r;
    if (s1_fire) begin
      out_nxt.result_byte = 8'd0;
      unique case (op)
        OP_ADD, OP_SUB: begin
          out_nxt.result_byte = ar.result;
          flags_nxt.c = ar.c;
          flags_nxt.x = ar.c;
          flags_nxt.v = ar.v;
          flags_nxt.n = ar.n;
          flags_nxt.z = flags_r.z & (ar.result == 8'd0);
        end
        OP_WFLAGS: flags_nxt = flags_t'(s1_r.flags_in);
        OP_TEST:   flags_nxt = flags_r;
        default:   flags_nxt = flags_r;
      endcase
      out_nxt.flags_out      = flags_nxt;
      out_nxt.condition_true = cond_holds;
    end
  end

  always_comb begin
    s1_nxt        = in_fire ? in_data : s1_r;
    s1_valid_nxt  = in_fire | (s1_valid_r & ~out_load);
    out_valid_nxt = s1_fire | (out_valid_r & out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      flags_r     <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      flags_r     <= flags_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_r  <= s1_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Flags move only when a request passes through execute
  a_flags_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_fire |=> $stable(flags_r))
    else $error("flags changed without a request in execute");

  // Decimal arithmetic never sets Z
  a_z_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && (op == OP_ADD || op == OP_SUB)) |=> !$rose(flags_r.z))
    else $error("Z set by decimal arithmetic");

  // Reported flags match the flag register after execute
  a_flags_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> (out_r.flags_out == flags_r))
    else $error("reported flags differ from flag register");

  // Input is held off only while both stages are full
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled with free space");

endmodule

[design/bcdcc_arith.sv]
// Packed-BCD add and subtract with extend, giving result byte and C, V, N.
module bcdcc_arith import bcdcc_pkg::*; (
  input  logic       subtract,
  input  logic [7:0] src,
  input  logic [7:0] dst,
  input  logic       x_in,
  output arith_res_t res
);

  logic [4:0] a_lo;
  logic [9:0] a_raw;
  logic [9:0] a_fix;
  logic       a_c;
  logic [9:0] a_res;

  logic [7:0] s_lo;
  logic [7:0] s_raw;
  logic       s_k;
  logic [9:0] s_diff;
  logic [9:0] s_cdiff;
  logic [7:0] s_res;
  logic       s_c;

  // Decimal add
  always_comb begin
    a_lo  = {1'b0, src[3:0]} + {1'b0, dst[3:0]} + {4'b0, x_in};
    a_raw = {2'b0, src[7:4], 4'b0} + {2'b0, dst[7:4], 4'b0} + {5'b0, a_lo};
    a_fix = a_raw + ((a_lo > {1'b0, LO_DIGIT_MAX}) ? LO_ADJ_WIDE : 10'd0);
    a_c   = (a_fix & ADD_CARRY_MASK) > ADD_CARRY_LIMIT;
    a_res = a_fix + (a_c ? HI_ADJ_WIDE : 10'd0);
  end

  // Decimal subtract; low digit borrow shows as a nonzero upper nibble of s_lo
  always_comb begin
    s_lo    = {4'b0, dst[3:0]} - {4'b0, src[3:0]} - {7'b0, x_in};
    s_raw   = {dst[7:4], 4'b0} - {src[7:4], 4'b0} + s_lo;
    s_k     = (s_lo[7:4] != 4'd0);
    s_diff  = {2'b0, dst} - {2'b0, src} - {9'b0, x_in};
    s_cdiff = s_diff - (s_k ? LO_ADJ_WIDE : 10'd0);
    s_c     = |s_cdiff[9:8];
    s_res   = s_raw - (s_k ? LO_ADJ : 8'd0) - (s_diff[8] ? HI_ADJ : 8'd0);
  end

  always_comb begin
    if (subtract) begin
      res.result = s_res;
      res.c      = s_c;
      res.v      = s_raw[7] & ~s_res[7];
    end else begin
      res.result = a_res[7:0];
      res.c      = a_c;
      res.v      = ~a_raw[7] & a_res[7];
    end
    res.n = res.result[7];
  end

endmodule

[design/bcdcc_cond.sv]
// Branch condition evaluation over the current flags.
module bcdcc_cond import bcdcc_pkg::*; (
  input  logic [3:0] condition,
  input  flags_t     flags,
  output logic       holds
);

  always_comb begin
    unique case (cond_t'(condition))
      CC_T:  holds = 1'b1;
      CC_F:  holds = 1'b0;
      CC_HI: holds = ~flags.c & ~flags.z;
      CC_LS: holds = flags.c | flags.z;
      CC_CC: holds = ~flags.c;
      CC_CS: holds = flags.c;
      CC_NE: holds = ~flags.z;
      CC_EQ: holds = flags.z;
      CC_VC: holds = ~flags.v;
      CC_VS: holds = flags.v;
      CC_PL: holds = ~flags.n;
      CC_MI: holds = flags.n;
      CC_GE: holds = (flags.n == flags.v);
      CC_LT: holds = (flags.n != flags.v);
      CC_GT: holds = (flags.n == flags.v) & ~flags.z;
      CC_LE: holds = (flags.n != flags.v) | flags.z;
      default: holds = 1'b0;
    endcase
  end

endmodule

[bench/tb.sv]
// Self-checking bench for the BCD condition-code unit: directed and random requests.
module tb;
  import bcdcc_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 8;

  logic clk;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_stall;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  flags_t ccr_flags;
  out_t   expected_results[$];
  int     mismatch_count = 0;
  int     send_idle_pct;
  int     stall_pct;
  int     quiet_cycles = 0;
  logic [3:0] next_cc;

  bcd_alu_condition_codes i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic cond_holds(logic [3:0] cc, flags_t f);
    case (cc)
      CC_T:    return 1'b1;
      CC_F:    return 1'b0;
      CC_HI:   return !f.c && !f.z;
      CC_LS:   return f.c || f.z;
      CC_CC:   return !f.c;
      CC_CS:   return f.c;
      CC_NE:   return !f.z;
      CC_EQ:   return f.z;
      CC_VC:   return !f.v;
      CC_VS:   return f.v;
      CC_PL:   return !f.n;
      CC_MI:   return f.n;
      CC_GE:   return f.n == f.v;
      CC_LT:   return f.n != f.v;
      CC_GT:   return (f.n == f.v) && !f.z;
      default: return (f.n != f.v) || f.z;
    endcase
  endfunction

  // Advances the flag copy by one request and returns the result it should give.
  function automatic out_t bcd_step(in_t req);
    out_t       res;
    logic [7:0] s;
    logic [7:0] d;
    logic [9:0] add_lo;
    logic [9:0] add_raw;
    logic [9:0] add_sum;
    logic [15:0] sub_lo;
    logic [15:0] sub_raw;
    logic [15:0] sub_diff;
    logic [31:0] borrow_chain;
    logic [31:0] lo_adj;
    s = req.source_byte;
    d = req.dest_byte;
    res = '0;
    res.condition_true = cond_holds(req.condition, ccr_flags);
    case (req.opcode)
      OP_ADD: begin
        add_lo  = {6'd0, s[3:0]} + {6'd0, d[3:0]} + {9'd0, ccr_flags.x};
        add_raw = {2'd0, s[7:4], 4'd0} + {2'd0, d[7:4], 4'd0} + add_lo;
        add_sum = add_raw;
        if (add_lo > 10'd9) add_sum = add_sum + 10'd6;
        ccr_flags.c = (add_sum & 10'h3F0) > 10'h090;
        ccr_flags.x = ccr_flags.c;
        if (ccr_flags.c) add_sum = add_sum + 10'h060;
        res.result_byte = add_sum[7:0];
        ccr_flags.n = add_sum[7];
        ccr_flags.v = !add_raw[7] && add_sum[7];
        if (add_sum[7:0] != 8'd0) ccr_flags.z = 1'b0;
      end
      OP_SUB: begin
        sub_lo   = {12'd0, d[3:0]} - {12'd0, s[3:0]} - {15'd0, ccr_flags.x};
        sub_raw  = {8'd0, d[7:4], 4'd0} - {8'd0, s[7:4], 4'd0} + sub_lo;
        sub_diff = sub_raw;
        lo_adj   = 32'd0;
        if (sub_lo[7:4] != 4'd0) begin
          lo_adj   = 32'd6;
          sub_diff = sub_diff - 16'd6;
        end
        borrow_chain = {24'd0, d} - {24'd0, s} - {31'd0, ccr_flags.x};
        if (borrow_chain[8]) sub_diff = sub_diff - 16'h0060;
        borrow_chain = borrow_chain - lo_adj;
        ccr_flags.c = borrow_chain[9:8] != 2'd0;
        ccr_flags.x = ccr_flags.c;
        res.result_byte = sub_diff[7:0];
        ccr_flags.n = sub_diff[7];
        ccr_flags.v = sub_raw[7] && !sub_diff[7];
        if (sub_diff[7:0] != 8'd0) ccr_flags.z = 1'b0;
      end
      OP_WFLAGS: ccr_flags = flags_t'(req.flags_in);
      default: ;
    endcase
    res.flags_out = ccr_flags;
    return res;
  endfunction

  task automatic report_mismatch(input string field, input logic [7:0] want,
                                 input logic [7:0] got);
    $display("%0t: %s expected %h, got %h", $time, field, want, got);
    mismatch_count++;
  endtask

  // Valid is only ever raised or lowered once per clock step.
  task automatic send_request(input in_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(bcd_step(req));
  endtask

  // Directed requests walk through all sixteen conditions in turn.
  task automatic send_directed(input op_t op, input logic [7:0] s, input logic [7:0] d,
                               input logic [4:0] f);
    in_t req;
    req.opcode      = op;
    req.source_byte = s;
    req.dest_byte   = d;
    req.condition   = next_cc;
    req.flags_in    = f;
    next_cc++;
    send_request(req);
  endtask

  function automatic logic [7:0] rand_operand();
    if ($urandom_range(99) < 80)
      return {4'($urandom_range(9)), 4'($urandom_range(9))};
    return 8'($urandom_range(255));
  endfunction

  task automatic test_bcd_extremes();
    send_directed(OP_ADD, 8'h99, 8'h99, 5'h00);
    send_directed(OP_ADD, 8'h99, 8'h99, 5'h00);
    send_directed(OP_ADD, 8'h00, 8'h00, 5'h00);
    send_directed(OP_ADD, 8'h01, 8'h00, 5'h00);
    send_directed(OP_ADD, 8'hFF, 8'hFF, 5'h1F);
    send_directed(OP_SUB, 8'h99, 8'h00, 5'h00);
    send_directed(OP_SUB, 8'h00, 8'h99, 5'h00);
    send_directed(OP_SUB, 8'h00, 8'h00, 5'h00);
    send_directed(OP_SUB, 8'h00, 8'hFF, 5'h1F);
    send_directed(OP_SUB, 8'hFF, 8'h00, 5'h00);
  endtask

  task automatic test_flag_load();
    send_directed(OP_WFLAGS, 8'hFF, 8'hFF, 5'h1F);
    send_directed(OP_TEST,   8'h00, 8'h00, 5'h00);
    send_directed(OP_WFLAGS, 8'h00, 8'h00, 5'h00);
    send_directed(OP_TEST,   8'hFF, 8'hFF, 5'h1F);
    send_directed(OP_WFLAGS, 8'h5A, 8'hA5, 5'h0A);
    send_directed(OP_TEST,   8'h00, 8'h00, 5'h15);
    send_directed(OP_WFLAGS, 8'h00, 8'h00, 5'h05);
  endtask

  // Z survives a zero result and is never set by arithmetic.
  task automatic test_sticky_zero();
    send_directed(OP_WFLAGS, 8'h00, 8'h00, 5'h04);
    send_directed(OP_ADD,    8'h00, 8'h00, 5'h00);
    send_directed(OP_SUB,    8'h00, 8'h00, 5'h00);
    send_directed(OP_ADD,    8'h01, 8'h00, 5'h00);
    send_directed(OP_ADD,    8'h00, 8'h00, 5'h00);
  endtask

  task automatic test_random_traffic(input int count, input int idle_pct,
                                     input int stall_rate);
    in_t req;
    int  pick;
    send_idle_pct = idle_pct;
    stall_pct     = stall_rate;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 35)      req.opcode = OP_ADD;
      else if (pick < 70) req.opcode = OP_SUB;
      else if (pick < 85) req.opcode = OP_WFLAGS;
      else                req.opcode = OP_TEST;
      req.source_byte = rand_operand();
      req.dest_byte   = rand_operand();
      req.condition   = 4'($urandom_range(15));
      req.flags_in    = 5'($urandom_range(31));
      send_request(req);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && $urandom_range(99) < stall_pct) out_stall <= 1'b1;
    else out_stall <= 1'b0;
  end

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", 8'h00, out_data.result_byte);
      end else begin
        want = expected_results.pop_front();
        if (out_data.result_byte !== want.result_byte)
          report_mismatch("result_byte", want.result_byte, out_data.result_byte);
        if (out_data.flags_out !== want.flags_out)
          report_mismatch("flags_out", 8'(want.flags_out), 8'(out_data.flags_out));
        if (out_data.condition_true !== want.condition_true)
          report_mismatch("condition_true", 8'(want.condition_true),
                          8'(out_data.condition_true));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("bcd_alu_condition_codes: mismatch");
      $finish;
    end
  end

  initial begin
    ccr_flags      = '0;
    send_idle_pct  = 0;
    stall_pct      = 0;
    next_cc        = 4'd0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_sticky_zero();
    test_bcd_extremes();
    test_flag_load();
    test_random_traffic(425, 0, 0);
    test_random_traffic(425, 63, 0);
    test_random_traffic(425, 0, 63);
    test_random_traffic(425, 25, 25);

    in_valid <= 1'b0;
    wait (expected_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) $display("bcd_alu_condition_codes: match");
    else $display("bcd_alu_condition_codes: mismatch");
    $finish;
  end

endmodule
